FILE: sv/bcs_pkg.sv
`default_nettype none
package bcs_pkg;

  localparam int unsigned MaxRes = 3;

  // input operations
  localparam logic [2:0] OpFrame     = 3'd0;
  localparam logic [2:0] OpStartReq  = 3'd1;
  localparam logic [2:0] OpStopReq   = 3'd2;
  localparam logic [2:0] OpStatus    = 3'd3;
  localparam logic [2:0] OpSpeed     = 3'd4;

  // result kinds
  localparam logic [1:0] KindTx      = 2'd0;
  localparam logic [1:0] KindStop    = 2'd1;
  localparam logic [1:0] KindStart   = 2'd2;
  localparam logic [1:0] KindAlarm   = 2'd3;

  // alarm codes
  localparam logic [1:0] AlarmCharger = 2'd0;
  localparam logic [1:0] AlarmBms     = 2'd1;
  localparam logic [1:0] AlarmFailed  = 2'd2;

  // robot status
  localparam logic [1:0] StatOther   = 2'd0;
  localparam logic [1:0] StatRunning = 2'd1;
  localparam logic [1:0] StatIdle    = 2'd2;
  localparam logic [1:0] StatBad     = 2'd3;

  // CAN identifiers
  localparam logic [10:0] IdChargerPoll  = 11'h0A1;
  localparam logic [10:0] IdChargerReply = 11'h0A0;
  localparam logic [10:0] IdPack         = 11'h351;
  localparam logic [10:0] IdBmsStatus    = 11'h352;

  // config register indexes
  localparam logic [7:0] RegStopSoc    = 8'd0;
  localparam logic [7:0] RegResumeSoc  = 8'd1;
  localparam logic [7:0] RegManualSpd  = 8'd2;
  localparam logic [7:0] RegFailLimit  = 8'd3;

  localparam logic [6:0]  StopSocRst   = 7'd79;
  localparam logic [6:0]  ResumeSocRst = 7'd75;
  localparam logic [14:0] ManualSpdRst = 15'd10;
  localparam logic [7:0]  FailLimitRst = 8'd100;
  localparam logic [7:0]  FailCountMax = 8'd255;

  typedef struct packed {
    logic [2:0]         operation;
    logic [10:0]        frame_id;
    logic [63:0]        frame_bytes;
    logic [1:0]         robot_status;
    logic signed [15:0] forward_speed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] tx_id;
    logic [63:0] tx_bytes;
    logic [1:0]  alarm_code;
    logic [25:0] fault_mask;
    logic        charge_enabled;
    logic        last;
  } out_item_t;

  typedef out_item_t [MaxRes-1:0] res_vec_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic [6:0]  stop_soc;
    logic [6:0]  resume_soc;
    logic [14:0] manual_speed_min;
    logic [7:0]  fail_limit;
  } cfg_t;

  typedef struct packed {
    logic               charge_on;
    logic               error_watch;
    logic               resume_pending;
    logic               manual_mark;
    logic [7:0]         fail_count;
    logic [15:0]        soc_percent;
    logic signed [15:0] pack_current;
    logic [1:0]         status_now;
    logic [1:0]         status_before;
    logic signed [15:0] speed_now;
  } state_t;

endpackage
`default_nettype wire

FILE: sv/bcs_if.sv
`default_nettype none
interface bcs_in_if;
  logic               valid;
  logic               ready;
  bcs_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcs_out_if;
  logic               valid;
  logic               ready;
  bcs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcs_cfg_if;
  logic               valid;
  logic               ready;
  bcs_pkg::cfg_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/bcs_step.sv
`default_nettype none
module bcs_step (
  input  bcs_pkg::in_item_t item_i,
  input  bcs_pkg::state_t   state_i,
  input  bcs_pkg::cfg_t     cfg_i,
  output bcs_pkg::state_t   state_o,
  output bcs_pkg::res_vec_t res_o,
  output logic [1:0]        nres_o
);
  import bcs_pkg::*;

  always_comb begin
    state_t      s;
    res_vec_t    r;
    logic [1:0]  n;
    logic [15:0] cur;
    logic [25:0] mask;
    logic [7:0]  fc;
    logic        started;
    logic        manual;
    logic [63:0] b;

    s    = state_i;
    r    = '0;
    n    = 2'd0;
    b    = item_i.frame_bytes;
    cur  = {b[23:16], b[31:24]};
    fc   = s.fail_count;
    mask = '0;
    started = 1'b0;
    manual  = 1'b0;

    unique case (item_i.operation)
      OpFrame: begin
        if (item_i.frame_id == IdChargerPoll) begin
          r[n].kind     = KindTx;
          r[n].tx_id    = IdChargerReply;
          r[n].tx_bytes = {63'd0, s.charge_on};
          n = n + 2'd1;
          if (b[7:0] != 8'd0 && s.error_watch) begin
            r[n].kind       = KindAlarm;
            r[n].alarm_code = AlarmCharger;
            n = n + 2'd1;
            r[n].kind = KindStop;
            n = n + 2'd1;
            s.error_watch = 1'b0;
            s.charge_on   = 1'b0;
          end
        end else if (item_i.frame_id == IdPack) begin
          s.soc_percent  = {b[39:32], b[47:40]};
          s.pack_current = $signed(cur);
          if (s.resume_pending && s.soc_percent <= {9'd0, cfg_i.resume_soc}) begin
            if (!s.charge_on) begin
              s.charge_on = 1'b1;
              r[n].kind = KindStart;
              n = n + 2'd1;
            end
            s.resume_pending = 1'b0;
          end
          if (s.charge_on && s.soc_percent >= {9'd0, cfg_i.stop_soc}) begin
            r[n].kind = KindStop;
            n = n + 2'd1;
            s.manual_mark    = 1'b1;
            s.resume_pending = 1'b1;
            s.charge_on      = 1'b0;
          end
          // running edge or manual push while idle cancels the pending resume
          started = (s.status_before != s.status_now) && (s.status_now == StatRunning);
          manual  = s.manual_mark && (s.speed_now >= $signed({1'b0, cfg_i.manual_speed_min}))
                    && (s.status_now == StatIdle);
          if (s.resume_pending && (started || manual)) begin
            s.resume_pending = 1'b0;
            s.manual_mark    = 1'b0;
          end
          s.status_before = s.status_now;
        end else if (item_i.frame_id == IdBmsStatus) begin
          if (s.charge_on) begin
            if (s.pack_current > 16'sd0) begin
              s.fail_count = '0;
            end else begin
              if (fc != FailCountMax) begin
                fc = fc + 8'd1;
              end
              s.fail_count = fc;
              if (fc >= cfg_i.fail_limit) begin
                r[n].kind       = KindAlarm;
                r[n].alarm_code = AlarmFailed;
                n = n + 2'd1;
                s.fail_count = '0;
                s.charge_on  = 1'b0;
              end
            end
          end
          for (int i = 0; i < 11; i++) begin
            mask[i] = b[2*i+1];
          end
          mask[16:11] = b[39:34];
          mask[24:17] = b[47:40];
          if (mask != '0) begin
            r[n].kind       = KindAlarm;
            r[n].alarm_code = AlarmBms;
            r[n].fault_mask = mask;
            n = n + 2'd1;
            r[n].kind = KindStop;
            n = n + 2'd1;
            s.charge_on = 1'b0;
          end
        end
      end
      OpStartReq: begin
        if (s.soc_percent < {9'd0, cfg_i.stop_soc}) begin
          s.charge_on      = 1'b1;
          s.error_watch    = 1'b1;
          s.resume_pending = 1'b0;
        end else begin
          s.charge_on      = 1'b0;
          s.resume_pending = 1'b1;
          s.manual_mark    = 1'b1;
          r[n].kind = KindStop;
          n = n + 2'd1;
        end
      end
      OpStopReq: begin
        s.charge_on = 1'b0;
      end
      OpStatus: begin
        s.status_now = (item_i.robot_status == StatBad) ? StatOther : item_i.robot_status;
      end
      OpSpeed: begin
        s.speed_now = item_i.forward_speed;
      end
      default: begin
      end
    endcase

    for (int k = 0; k < MaxRes; k++) begin
      r[k].charge_enabled = s.charge_on;
      r[k].last           = (n != 2'd0) && (k[1:0] == n - 2'd1);
    end

    state_o = s;
    res_o   = r;
    nres_o  = n;
  end

endmodule
`default_nettype wire

FILE: sv/battery_charge_supervisor.sv
`default_nettype none
// Channel  Dir  Payload                                   Notes
// in_i     in   operation, frame_id, frame_bytes,         CAN frame or host event
//               robot_status, forward_speed
// out_o    out  kind, tx_id, tx_bytes, alarm_code,        0..3 results per request,
//               fault_mask, charge_enabled, last          last marks the final one
// cfg_i    in   index (8b), value (16b)                   regs 0..3, always ready
//
// A request is evaluated in the cycle it is accepted; state updates at that edge and
// its results (up to three) land in a small result buffer, one result per cycle out
// while out_o.ready is high. A request that yields no result or one result can follow
// every cycle; one with more results holds in_i off while the buffer drains.
// in_i.ready is high when the buffer is empty or its last result goes out this cycle,
// so a stalled sink stalls the input while any result of the previous request is held.
// rst_ni (async, low) clears all supervisor state and loads register defaults.
module battery_charge_supervisor (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bcs_in_if.sink     in_i,
  bcs_out_if.source  out_o,
  bcs_cfg_if.sink    cfg_i
);
  import bcs_pkg::*;

  state_t     state_q, state_d;
  cfg_t       cfg_q;
  res_vec_t   res_q, res_d;
  logic [1:0] cnt_q;     // results held for the current request
  logic [1:0] idx_q;     // next result to present
  logic [1:0] nres;
  logic       in_acc;
  logic       out_acc;
  logic       out_done;

  bcs_step u_step (
    .item_i  (in_i.data),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (res_d),
    .nres_o  (nres)
  );

  assign out_acc  = out_o.valid && out_o.ready;
  assign out_done = out_acc && (idx_q == cnt_q - 2'd1);
  assign in_i.ready = (cnt_q == 2'd0) || out_done;
  assign in_acc = in_i.valid && in_i.ready;

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = res_q[idx_q];

  assign cfg_i.ready = 1'b1;

  // supervisor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_soc         <= StopSocRst;
      cfg_q.resume_soc       <= ResumeSocRst;
      cfg_q.manual_speed_min <= ManualSpdRst;
      cfg_q.fail_limit       <= FailLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        RegStopSoc:   cfg_q.stop_soc         <= cfg_i.data.value[6:0];
        RegResumeSoc: cfg_q.resume_soc       <= cfg_i.data.value[6:0];
        RegManualSpd: cfg_q.manual_speed_min <= cfg_i.data.value[14:0];
        RegFailLimit: cfg_q.fail_limit       <= cfg_i.data.value[7:0];
        default: begin
        end
      endcase
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (in_acc) begin
      cnt_q <= nres;
      idx_q <= '0;
    end else if (out_done) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (out_acc) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import bcs_pkg::*;

  // Operation codes the block ignores
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  // Status frame bits that feed no fault flag: low bit of each pair, byte 2 pair 3,
  // byte 3, byte 4 bits 0..1, bytes 6..7
  localparam logic [63:0] NoFaultBits = 64'hFFFF_0003_FFD5_5555;

  localparam int unsigned CycleLimit = 200000;
  // results can still be in the output buffer when the last expected one has gone
  localparam int unsigned SettleCycles = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bcs_in_if  in_if ();
  bcs_out_if out_if ();
  bcs_cfg_if cfg_if ();

  battery_charge_supervisor DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  in_item_t    req_q[$];      // requests waiting for the driver
  out_item_t   reply_q[$];    // predicted results, oldest first
  cfg_t        cfg_now;       // register copy, follows accepted writes
  state_t      sup;           // predicted supervisor state
  int unsigned queued_cnt;
  int unsigned taken_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  logic        req_taken;     // set at the edge a request goes in, cleared by the driver
  logic        reply_taken;   // set at the edge a result goes out, cleared by the sink
  int unsigned req_gap;
  int unsigned reply_stall;
  logic        no_idle;       // stretches without gaps or stalls on either side

  // ---------------------------------------------------------------------------
  // Supervisor prediction
  // ---------------------------------------------------------------------------
  function automatic out_item_t mk_reply(input logic [1:0] kind, input logic [1:0] code,
                                         input logic [25:0] mask);
    out_item_t r;
    r = '0;
    r.kind       = kind;
    r.alarm_code = code;
    r.fault_mask = mask;
    return r;
  endfunction

  task automatic predict_replies(input in_item_t req);
    out_item_t   batch[$];
    out_item_t   r;
    logic [25:0] faults;
    logic        started;
    logic        manual;
    int          i;
    case (req.operation)
      OpFrame: begin
        if (req.frame_id == IdChargerPoll) begin
          // reply carries the flag as it was before this poll
          r = mk_reply(KindTx, AlarmCharger, '0);
          r.tx_id    = IdChargerReply;
          r.tx_bytes = {63'd0, sup.charge_on};
          batch = {batch, r};
          // charger reports an error after a start: one alarm, then stop
          if (req.frame_bytes[7:0] != 8'd0 && sup.error_watch) begin
            batch = {batch, mk_reply(KindAlarm, AlarmCharger, '0)};
            batch = {batch, mk_reply(KindStop, AlarmCharger, '0)};
            sup.error_watch = 1'b0;
            sup.charge_on   = 1'b0;
          end
        end else if (req.frame_id == IdPack) begin
          // current in bytes 2..3, SOC in bytes 4..5, big endian
          sup.pack_current = {req.frame_bytes[23:16], req.frame_bytes[31:24]};
          sup.soc_percent  = {req.frame_bytes[39:32], req.frame_bytes[47:40]};
          if (sup.resume_pending && sup.soc_percent <= cfg_now.resume_soc) begin
            if (!sup.charge_on) begin
              sup.charge_on = 1'b1;
              batch = {batch, mk_reply(KindStart, AlarmCharger, '0)};
            end
            sup.resume_pending = 1'b0;
          end
          if (sup.charge_on && sup.soc_percent >= cfg_now.stop_soc) begin
            batch = {batch, mk_reply(KindStop, AlarmCharger, '0)};
            sup.manual_mark    = 1'b1;
            sup.resume_pending = 1'b1;
            sup.charge_on      = 1'b0;
          end
          // pending resume dropped once the robot starts or is pushed while idle
          if (sup.resume_pending) begin
            started = sup.status_before != sup.status_now && sup.status_now == StatRunning;
            manual  = sup.manual_mark && sup.status_now == StatIdle &&
                      $signed(sup.speed_now) >= $signed({1'b0, cfg_now.manual_speed_min});
            if (started || manual) begin
              sup.resume_pending = 1'b0;
              sup.manual_mark    = 1'b0;
            end
          end
          sup.status_before = sup.status_now;
        end else if (req.frame_id == IdBmsStatus) begin
          if (sup.charge_on) begin
            if ($signed(sup.pack_current) > 0) begin
              sup.fail_count = '0;
            end else begin
              if (sup.fail_count != FailCountMax) sup.fail_count++;
              if (sup.fail_count >= cfg_now.fail_limit) begin
                batch = {batch, mk_reply(KindAlarm, AlarmFailed, '0)};
                sup.fail_count = '0;
                sup.charge_on  = 1'b0;
              end
            end
          end
          // the upper bit of each pair in bits 0..21 flags a fault, as does each of bits 34..47
          faults = '0;
          for (i = 0; i < 11; i++) faults[i] = req.frame_bytes[8*(i/4) + 2*(i%4) + 1];
          faults[16:11] = req.frame_bytes[39:34];
          faults[24:17] = req.frame_bytes[47:40];
          if (faults != '0) begin
            batch = {batch, mk_reply(KindAlarm, AlarmBms, faults)};
            batch = {batch, mk_reply(KindStop, AlarmCharger, '0)};
            sup.charge_on = 1'b0;
          end
        end
      end
      OpStartReq: begin
        if (sup.soc_percent < cfg_now.stop_soc) begin
          sup.charge_on      = 1'b1;
          sup.error_watch    = 1'b1;
          sup.resume_pending = 1'b0;
        end else begin
          // already full: refuse and wait for the resume level
          sup.charge_on      = 1'b0;
          sup.resume_pending = 1'b1;
          sup.manual_mark    = 1'b1;
          batch = {batch, mk_reply(KindStop, AlarmCharger, '0)};
        end
      end
      OpStopReq: sup.charge_on = 1'b0;
      OpStatus:  sup.status_now = (req.robot_status == StatBad) ? StatOther : req.robot_status;
      OpSpeed:   sup.speed_now = req.forward_speed;
      default: ;
    endcase
    // flag after the whole request, last marks the final result
    for (i = 0; i < batch.size(); i++) begin
      batch[i].charge_enabled = sup.charge_on;
      batch[i].last           = (i == batch.size() - 1);
      reply_q = {reply_q, batch[i]};
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: results checked and requests predicted at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      reply_taken = 1'b1;
      if (reply_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with nothing expected, expected none, actual kind %0d",
                 $time, out_if.data.kind);
      end else begin
        want = reply_q.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_if.data.kind));
        check_field("tx_id", 64'(want.tx_id), 64'(out_if.data.tx_id));
        check_field("tx_bytes", want.tx_bytes, out_if.data.tx_bytes);
        check_field("alarm_code", 64'(want.alarm_code), 64'(out_if.data.alarm_code));
        check_field("fault_mask", 64'(want.fault_mask), 64'(out_if.data.fault_mask));
        check_field("charge_enabled", 64'(want.charge_enabled),
                    64'(out_if.data.charge_enabled));
        check_field("last", 64'(want.last), 64'(out_if.data.last));
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      req_taken = 1'b1;
      taken_cnt++;
      predict_replies(in_if.data);
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: falling edge, an idle gap drawn at random after each request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    logic send;
    if (rst_n) begin
      send = in_if.valid && !req_taken;
      if (req_taken) begin
        req_taken = 1'b0;
        if ($urandom_range(0, 24) == 0) no_idle = ~no_idle;
        req_gap = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (!send) begin
        if (req_gap != 0) begin
          req_gap--;
        end else if (req_q.size() != 0) begin
          in_if.data <= req_q.pop_front();
          send = 1'b1;
        end
      end
      in_if.valid <= send;
    end
  end

  // Result sink: a random stall drawn after each result, none while no_idle is set
  always @(negedge clk) begin
    if (rst_n) begin
      if (reply_taken) begin
        reply_taken = 1'b0;
        reply_stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (reply_stall != 0) begin
        reply_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t frame_req(input logic [10:0] id, input logic [63:0] bytes);
    in_item_t r;
    r = '0;
    r.operation   = OpFrame;
    r.frame_id    = id;
    r.frame_bytes = bytes;
    return r;
  endfunction

  function automatic in_item_t host_event(input logic [2:0] op, input logic [1:0] stat,
                                          input logic [15:0] speed);
    in_item_t r;
    r = '0;
    r.operation     = op;
    r.robot_status  = stat;
    r.forward_speed = speed;
    return r;
  endfunction

  // pack frame payload: current bytes 2..3, SOC bytes 4..5
  function automatic logic [63:0] pack_payload(input logic [15:0] soc, input logic [15:0] cur);
    return {16'h0, soc[7:0], soc[15:8], cur[7:0], cur[15:8], 16'h0};
  endfunction

  // Mostly well-formed traffic around the current thresholds, some noise
  function automatic in_item_t random_req();
    in_item_t    r;
    int unsigned pick;
    int unsigned bit_no;
    int          lvl;
    logic [15:0] cur;
    logic [63:0] pay;
    r.operation     = OpFrame;
    r.frame_id      = 11'($urandom_range(0, 2047));
    r.frame_bytes   = {$urandom, $urandom};
    r.robot_status  = 2'($urandom_range(0, 3));
    r.forward_speed = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      r.frame_id = IdPack;
      case ($urandom_range(0, 9))
        0, 1:    lvl = $urandom_range(0, 127);
        2:       lvl = $urandom_range(0, 65535);
        3, 4, 5: lvl = int'(cfg_now.stop_soc) + int'($urandom_range(0, 6)) - 3;
        default: lvl = int'(cfg_now.resume_soc) + int'($urandom_range(0, 6)) - 3;
      endcase
      if (lvl < 0) lvl = 0;
      cur = $urandom_range(0, 1) ? 16'($urandom_range(1, 3000)) : 16'($urandom);
      pay = pack_payload(16'(lvl), cur);
      r.frame_bytes[47:16] = pay[47:16];
    end else if (pick < 38) begin
      r.frame_id = IdBmsStatus;
      case ($urandom_range(0, 19))
        15, 16, 17: begin
          // a single fault flag
          bit_no = $urandom_range(0, 24);
          r.frame_bytes &= NoFaultBits;
          if (bit_no < 11) r.frame_bytes[8*(bit_no/4) + 2*(bit_no%4) + 1] = 1'b1;
          else r.frame_bytes[bit_no + 23] = 1'b1;
        end
        18, 19: ;
        default: r.frame_bytes &= NoFaultBits;
      endcase
    end else if (pick < 56) begin
      r.frame_id = IdChargerPoll;
      if ($urandom_range(0, 1)) r.frame_bytes[7:0] = 8'h00;
    end else if (pick < 66) begin
      r.operation = OpStartReq;
    end else if (pick < 71) begin
      r.operation = OpStopReq;
    end else if (pick < 81) begin
      r.operation = OpStatus;
    end else if (pick < 91) begin
      r.operation = OpSpeed;
      if ($urandom_range(0, 1))
        r.forward_speed = 16'(int'(cfg_now.manual_speed_min) + int'($urandom_range(0, 4)) - 2);
    end else if (pick < 96) begin
      // unrelated identifier, normally ignored
    end else begin
      r.operation = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    end
    return r;
  endfunction

  task automatic post(input in_item_t r);
    req_q = {req_q, r};
    queued_cnt++;
  endtask

  // every request in, every result out, then let the output buffer empty
  task automatic settle();
    while (taken_cnt != queued_cnt || reply_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_if.data  <= '{index: idx, value: val};
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      RegStopSoc:   cfg_now.stop_soc         = val[6:0];
      RegResumeSoc: cfg_now.resume_soc       = val[6:0];
      RegManualSpd: cfg_now.manual_speed_min = val[14:0];
      RegFailLimit: cfg_now.fail_limit       = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_cfg(input int unsigned stop_lvl, input int unsigned resume_lvl,
                           input int unsigned spd, input int unsigned fails);
    write_reg(RegStopSoc, 16'(stop_lvl));
    write_reg(RegResumeSoc, 16'(resume_lvl));
    write_reg(RegManualSpd, 16'(spd));
    write_reg(RegFailLimit, 16'(fails));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stop_lvl;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    queued_cnt   = 0;
    taken_cnt    = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    req_taken    = 1'b0;
    reply_taken  = 1'b0;
    req_gap      = 0;
    reply_stall  = 0;
    no_idle      = 1'b0;
    cfg_now      = '{StopSocRst, ResumeSocRst, ManualSpdRst, FailLimitRst};
    sup          = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass on reset thresholds (stop 79, resume 75)
    post(frame_req(IdChargerPoll, 64'h0));                     // reply with charging off
    post(host_event(OpStartReq, StatOther, 16'h0));            // SOC 0: charging on
    post(frame_req(IdChargerPoll, 64'hFFFF_FFFF_FFFF_FF00));   // no charger error
    post(frame_req(IdChargerPoll, 64'h0000_0000_0000_00FF));   // charger error: alarm + stop
    post(host_event(OpStartReq, StatOther, 16'h0));
    post(frame_req(IdPack, pack_payload(16'd80, 16'h0100)));   // stop level: stop, pending
    post(frame_req(IdPack, pack_payload(16'd75, 16'h0100)));   // resume level: start
    post(frame_req(IdPack, pack_payload(16'd79, 16'h0100)));   // exactly stop level
    post(host_event(OpStatus, StatRunning, 16'h0));
    post(frame_req(IdPack, pack_payload(16'd78, 16'h7FFF)));   // robot started: cancel resume
    post(host_event(OpStartReq, StatOther, 16'h0));
    post(frame_req(IdBmsStatus, NoFaultBits));                 // current flowing, no fault
    post(frame_req(IdPack, pack_payload(16'd50, 16'h8000)));   // most negative current
    post(frame_req(IdBmsStatus, 64'h0));                       // one attempt without current
    post(frame_req(IdBmsStatus, '1));                          // every fault, reserved bit clear
    post(host_event(OpStartReq, StatOther, 16'h0));
    post(frame_req(IdPack, pack_payload(16'd100, 16'h0)));
    post(host_event(OpStatus, StatIdle, 16'h0));
    post(host_event(OpSpeed, StatOther, 16'h7FFF));
    post(frame_req(IdPack, pack_payload(16'd100, 16'hFFFF))); // moved while idle: cancel resume
    post(host_event(OpStartReq, StatOther, 16'h0));            // already full: stop command
    post(host_event(OpStatus, StatBad, 16'h0));                // stored as other
    post(host_event(OpSpeed, StatOther, 16'h8000));
    post(host_event(OpUnusedLo, StatBad, 16'hFFFF));           // ignored
    post(host_event(OpUnusedHi, StatBad, 16'hFFFF));
    post(frame_req(11'h7FF, '1));                              // unknown identifier
    post(host_event(OpStopReq, StatOther, 16'h0));
    settle();

    // Random phases across register settings, extremes included
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_cfg(100, 0, 0, 1);
        1: apply_cfg(0, 100, 32767, 2);
        2: apply_cfg(127, 127, 5, 3);
        3: apply_cfg(60, 40, 100, 0);   // zero limit: first dry attempt alarms
        default: begin
          stop_lvl = $urandom_range(1, 100);
          apply_cfg(stop_lvl, $urandom_range(0, stop_lvl), $urandom_range(0, 200),
                    $urandom_range(1, 6));
        end
      endcase
      repeat (18) post(random_req());
      settle();
    end

    // Charge with no current until the failed-charging alarm
    apply_cfg(79, 75, 10, 12);
    post(frame_req(IdPack, pack_payload(16'd10, 16'h0)));
    post(host_event(OpStartReq, StatOther, 16'h0));
    repeat (12) post(frame_req(IdBmsStatus, 64'h0));
    post(frame_req(IdChargerPoll, 64'h0));
    settle();

    if (mismatch_cnt == 0 && reply_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
